>>> rtl/serial_command_frame_parser_macros.svh
// assertion macros shared by the frame parser checker
`ifndef SERIAL_COMMAND_FRAME_PARSER_MACROS_SVH
`define SERIAL_COMMAND_FRAME_PARSER_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define SCFP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define SCFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/scfp_pkg.sv
// types, codes and helper functions of the serial command frame parser
package scfp_pkg;

    localparam int BUF_BYTES_DEF = 64;

    // parse phases
    localparam logic [3:0] PH_DOLLAR  = 4'd0;
    localparam logic [3:0] PH_LETTER  = 4'd1;
    localparam logic [3:0] PH_COMMA   = 4'd2;
    localparam logic [3:0] PH_N1_LEAD = 4'd3;
    localparam logic [3:0] PH_N1_BODY = 4'd4;
    localparam logic [3:0] PH_N2_LEAD = 4'd5;
    localparam logic [3:0] PH_N2_BODY = 4'd6;
    localparam logic [3:0] PH_STOP    = 4'd7;
    localparam logic [3:0] PH_DONE    = 4'd8;
    localparam logic [3:0] PH_FAIL    = 4'd9;

    // command kinds, also the result command codes
    localparam logic [1:0] CMD_NONE = 2'd0;
    localparam logic [1:0] CMD_STOP = 2'd1;
    localparam logic [1:0] CMD_MODE = 2'd2;
    localparam logic [1:0] CMD_MOVE = 2'd3;

    // characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_S      = 8'h53;

    typedef struct packed {
        logic [3:0]  phase;
        logic [1:0]  kind;
        logic        neg;
        logic        digit;
        logic [15:0] first;
        logic [15:0] second;
    } t_frame;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [15:0] left_speed;
        logic signed [15:0] right_speed;
        logic [7:0]         mode_now;
    } t_result;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    // mag * 10 + digit, wrapping at 16 bits
    function automatic logic [15:0] accumulate(input logic [15:0] mag, input logic [3:0] nib);
        return (mag << 3) + (mag << 1) + {12'b0, nib};
    endfunction

    function automatic logic [15:0] apply_sign(input logic [15:0] mag, input logic neg);
        return neg ? (16'd0 - mag) : mag;
    endfunction

    // positive speeds drop to zero while an obstacle is reported
    function automatic logic [15:0] clamp_forward(input logic [15:0] v, input logic obs);
        return (obs && v != 16'd0 && !v[15]) ? 16'd0 : v;
    endfunction

endpackage

>>> rtl/scfp_parse.sv
// per-byte parse state machine and frame byte counter
module scfp_parse #(
    parameter int BUF_BYTES = scfp_pkg::BUF_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_byte_acc,
    input  logic [7:0]       i_data,
    input  logic             i_frame_end,
    output scfp_pkg::t_frame o_frame
);
    import scfp_pkg::*;

    localparam int CntW = $clog2(BUF_BYTES);

    logic [CntW-1:0] r_count, n_count;
    logic            r_ended, n_ended;
    t_frame          r_frame, n_frame;

    always_comb begin
        n_count = r_count;
        n_ended = r_ended;
        n_frame = r_frame;
        if (i_frame_end) begin
            n_count = '0;
            n_ended = 1'b0;
            n_frame = '0;
            n_frame.phase = PH_DOLLAR;
        end else if (i_byte_acc && !r_ended && r_count != CntW'(BUF_BYTES - 1)) begin
            n_count = r_count + CntW'(1);
            if (i_data == CH_NUL) begin
                n_ended = 1'b1;
            end else begin
                unique case (r_frame.phase) inside
                    PH_DOLLAR: begin
                        n_frame.phase = (i_data == CH_DOLLAR) ? PH_LETTER : PH_FAIL;
                    end
                    PH_LETTER: begin
                        if (i_data == CH_S) begin
                            n_frame.kind  = CMD_STOP;
                            n_frame.phase = PH_STOP;
                        end else if (i_data == CH_A) begin
                            n_frame.kind  = CMD_MODE;
                            n_frame.phase = PH_COMMA;
                        end else if (i_data == CH_M) begin
                            n_frame.kind  = CMD_MOVE;
                            n_frame.phase = PH_COMMA;
                        end else begin
                            n_frame.phase = PH_FAIL;
                        end
                    end
                    PH_COMMA: begin
                        n_frame.phase = (i_data == CH_COMMA) ? PH_N1_LEAD : PH_FAIL;
                    end
                    PH_N1_LEAD: begin
                        if (is_space(i_data)) begin
                            n_frame.phase = PH_N1_LEAD;
                        end else if (i_data == CH_PLUS) begin
                            n_frame.phase = PH_N1_BODY;
                        end else if (i_data == CH_MINUS) begin
                            n_frame.neg   = 1'b1;
                            n_frame.phase = PH_N1_BODY;
                        end else if (is_digit(i_data)) begin
                            n_frame.first = accumulate(r_frame.first, i_data[3:0]);
                            n_frame.digit = 1'b1;
                            n_frame.phase = PH_N1_BODY;
                        end else begin
                            n_frame.phase = PH_FAIL;
                        end
                    end
                    PH_N1_BODY: begin
                        if (is_digit(i_data)) begin
                            n_frame.first = accumulate(r_frame.first, i_data[3:0]);
                            n_frame.digit = 1'b1;
                        end else if (!r_frame.digit) begin
                            n_frame.phase = PH_FAIL;
                        end else begin
                            n_frame.first = apply_sign(r_frame.first, r_frame.neg);
                            if (r_frame.kind == CMD_MODE) begin
                                n_frame.phase = PH_DONE;
                            end else if (i_data == CH_COMMA) begin
                                n_frame.neg   = 1'b0;
                                n_frame.digit = 1'b0;
                                n_frame.phase = PH_N2_LEAD;
                            end else begin
                                n_frame.phase = PH_FAIL;
                            end
                        end
                    end
                    PH_N2_LEAD: begin
                        if (is_space(i_data)) begin
                            n_frame.phase = PH_N2_LEAD;
                        end else if (i_data == CH_PLUS) begin
                            n_frame.phase = PH_N2_BODY;
                        end else if (i_data == CH_MINUS) begin
                            n_frame.neg   = 1'b1;
                            n_frame.phase = PH_N2_BODY;
                        end else if (is_digit(i_data)) begin
                            n_frame.second = accumulate(r_frame.second, i_data[3:0]);
                            n_frame.digit  = 1'b1;
                            n_frame.phase  = PH_N2_BODY;
                        end else begin
                            n_frame.phase = PH_FAIL;
                        end
                    end
                    PH_N2_BODY: begin
                        if (is_digit(i_data)) begin
                            n_frame.second = accumulate(r_frame.second, i_data[3:0]);
                            n_frame.digit  = 1'b1;
                        end else if (!r_frame.digit) begin
                            n_frame.phase = PH_FAIL;
                        end else begin
                            n_frame.second = apply_sign(r_frame.second, r_frame.neg);
                            n_frame.phase  = PH_DONE;
                        end
                    end
                    PH_STOP, PH_DONE, PH_FAIL: begin
                        n_frame.phase = r_frame.phase;
                    end
                    default: begin
                        n_frame.phase = PH_FAIL;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ended <= 1'b0;
            r_frame <= '0;
        end else begin
            r_count <= n_count;
            r_ended <= n_ended;
            r_frame <= n_frame;
        end
    end

    assign o_frame = r_frame;

endmodule

>>> rtl/scfp_decode.sv
// frame-end evaluation and stored mode register
module scfp_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_frame_end,
    input  logic              i_obstacle,
    input  scfp_pkg::t_frame  i_frame,
    output scfp_pkg::t_result o_result
);
    import scfp_pkg::*;

    logic [7:0]  r_mode, n_mode;
    logic [15:0] v1, v2, mode_pick, right_val;
    logic        mode_ok, move_ok;

    always_comb begin
        v1        = apply_sign(i_frame.first, i_frame.neg);
        v2        = apply_sign(i_frame.second, i_frame.neg);
        mode_pick = (i_frame.phase == PH_N1_BODY) ? v1 : i_frame.first;
        right_val = (i_frame.phase == PH_N2_BODY) ? v2 : i_frame.second;
        mode_ok   = (i_frame.kind == CMD_MODE) &&
                    ((i_frame.phase == PH_N1_BODY && i_frame.digit) ||
                     i_frame.phase == PH_DONE);
        move_ok   = (i_frame.kind == CMD_MOVE) &&
                    ((i_frame.phase == PH_N2_BODY && i_frame.digit) ||
                     i_frame.phase == PH_DONE);

        n_mode               = r_mode;
        o_result.command     = CMD_NONE;
        o_result.left_speed  = '0;
        o_result.right_speed = '0;
        if (i_frame.phase == PH_STOP) begin
            o_result.command = CMD_STOP;
        end else if (mode_ok) begin
            n_mode           = mode_pick[7:0];
            o_result.command = CMD_MODE;
        end else if (move_ok) begin
            o_result.command     = CMD_MOVE;
            o_result.left_speed  = $signed(clamp_forward(i_frame.first, i_obstacle));
            o_result.right_speed = $signed(clamp_forward(right_val, i_obstacle));
        end
        o_result.mode_now = n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= '0;
        end else if (i_frame_end) begin
            r_mode <= n_mode;
        end
    end

endmodule

>>> rtl/scfp_out.sv
// result register with one skid entry
module scfp_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  scfp_pkg::t_result i_result,
    input  logic              i_stall,
    output logic              o_valid,
    output logic              o_full,
    output scfp_pkg::t_result o_result
);
    import scfp_pkg::*;

    logic    r_out_vld, r_skid_vld;
    t_result r_out, r_skid;
    logic    pop;

    assign pop = r_out_vld && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (pop) begin
                r_skid_vld <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_vld || pop) begin
                r_out_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end else if (pop) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (!r_out_vld || pop) begin
                r_out <= i_result;
            end else begin
                r_skid <= i_result;
            end
        end
    end

    assign o_valid  = r_out_vld;
    assign o_full   = r_skid_vld;
    assign o_result = r_out;

endmodule

>>> rtl/serial_command_frame_parser.sv
// top level of the serial command frame parser
//
// channel   direction  handshake           payload
// input     in         i_valid / o_stall   i_req_type, i_data_byte, i_obstacle
// result    out        o_valid / i_stall   o_command, o_left_speed, o_right_speed,
//                                          o_mode_now
//
// one input transfer per cycle while o_stall is low; a byte updates the parse state in that cycle
// a frame end yields its result on o_valid the cycle after the transfer,
// later only while an earlier result is still waiting
// bytes never produce a result; each frame end produces exactly one
// a result register plus one skid entry part the sides; o_stall rises only
// when both hold results, so a waiting result does not block input
// i_rst_n is synchronous, active low; it clears parse state, mode and valids
module serial_command_frame_parser #(
    parameter int BUF_BYTES = scfp_pkg::BUF_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_req_type,
    input  logic [7:0]         i_data_byte,
    input  logic               i_obstacle,
    // result channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_command,
    output logic signed [15:0] o_left_speed,
    output logic signed [15:0] o_right_speed,
    output logic [7:0]         o_mode_now
);
    import scfp_pkg::*;

    logic    in_xfer;
    logic    byte_acc;
    logic    frame_end;
    logic    out_full;
    t_frame  frame;
    t_result result_d;
    t_result result_q;

    // input transfer when valid and not stalled
    assign in_xfer   = i_valid && !o_stall;
    assign byte_acc  = in_xfer && !i_req_type;
    assign frame_end = in_xfer && i_req_type;

    // byte-level parse state
    scfp_parse #(
        .BUF_BYTES (BUF_BYTES)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte_acc  (byte_acc),
        .i_data      (i_data_byte),
        .i_frame_end (frame_end),
        .o_frame     (frame)
    );

    // frame-end evaluation, mode register
    scfp_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_frame_end (frame_end),
        .i_obstacle  (i_obstacle),
        .i_frame     (frame),
        .o_result    (result_d)
    );

    // result register and skid
    scfp_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (frame_end),
        .i_result (result_d),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_full   (out_full),
        .o_result (result_q)
    );

    // stall input only while both result slots are occupied
    assign o_stall       = out_full;
    assign o_command     = result_q.command;
    assign o_left_speed  = result_q.left_speed;
    assign o_right_speed = result_q.right_speed;
    assign o_mode_now    = result_q.mode_now;

endmodule

>>> rtl/scfp_checker.sv
// port-level checker for the serial command frame parser, with its bind
`include "serial_command_frame_parser_macros.svh"

module scfp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               i_req_type,
    input logic               o_valid,
    input logic               i_stall,
    input logic [1:0]         o_command,
    input logic signed [15:0] o_left_speed,
    input logic signed [15:0] o_right_speed,
    input logic [7:0]         o_mode_now
);
    import scfp_pkg::*;

    // a stalled result holds
    `SCFP_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_command) && $stable(o_left_speed) && $stable(o_right_speed) && $stable(o_mode_now), "stalled result changed")

    // only a move carries nonzero speeds
    `SCFP_ASSERT_NOW(a_speed_zero, o_valid && o_command != CMD_MOVE, o_left_speed == 16'sd0 && o_right_speed == 16'sd0, "speed set on non-move result")

    // input stalls only with a result waiting
    `SCFP_ASSERT_NOW(a_stall_full, o_stall, o_valid, "input stalled with no result held")

    // without a frame-end transfer an empty output stays empty
    `SCFP_ASSERT_NEXT(a_no_spurious, !o_valid && !(i_valid && !o_stall && i_req_type), !o_valid, "result without frame end")

endmodule

bind serial_command_frame_parser scfp_checker u_scfp_checker (.*);

>>> dv/testbench.sv
// self-checking testbench for the serial command frame parser
module testbench;
    import scfp_pkg::*;

    // characters the stimulus and the parser model need beyond the package set
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // request kinds on the input channel
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_IDLE = 1'b1;

    localparam int FRAME_LIMIT   = BUF_BYTES_DEF - 1;
    localparam int RANDOM_EVENTS = 850;
    localparam int LONG_HOLD     = 250;
    localparam int QUIET_LIMIT   = 2000;

    typedef struct packed {
        logic       req;
        logic [7:0] ch;
        logic       obs;
    } t_link_event;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic               i_req_type = 1'b0;
    logic [7:0]         i_data_byte = 8'h00;
    logic               i_obstacle = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [1:0]         o_command;
    logic signed [15:0] o_left_speed;
    logic signed [15:0] o_right_speed;
    logic [7:0]         o_mode_now;

    serial_command_frame_parser i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_req_type    (i_req_type),
        .i_data_byte   (i_data_byte),
        .i_obstacle    (i_obstacle),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_command     (o_command),
        .o_left_speed  (o_left_speed),
        .o_right_speed (o_right_speed),
        .o_mode_now    (o_mode_now)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // frame parser model: its own copy of the per-frame state and the mode
    // ------------------------------------------------------------------
    logic [6:0]  byte_count;
    logic [3:0]  parse_state;
    logic [1:0]  frame_kind;
    logic        text_stopped;
    logic        sign_neg;
    logic        saw_digit;
    logic [15:0] num_left;
    logic [15:0] num_right;
    logic [7:0]  stored_mode;

    t_result     expected_replies[$];

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_decimal(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // decimal shift-in, wraps at 16 bits like a short
    function automatic logic [15:0] append_digit(input logic [15:0] mag, input logic [7:0] c);
        logic [15:0] d;
        d = {8'h00, c - CH_ZERO};
        return mag * 16'd10 + d;
    endfunction

    function automatic logic [15:0] signed_mag(input logic [15:0] mag, input logic neg);
        return neg ? (~mag + 16'd1) : mag;
    endfunction

    // an obstacle blocks forward motion only
    function automatic logic [15:0] forward_clamp(input logic [15:0] v, input logic obs);
        if (obs && v != 16'd0 && v[15] == 1'b0)
            return 16'd0;
        return v;
    endfunction

    task automatic clear_frame_state();
        byte_count   = '0;
        parse_state  = PH_DOLLAR;
        frame_kind   = CMD_NONE;
        text_stopped = 1'b0;
        sign_neg     = 1'b0;
        saw_digit    = 1'b0;
        num_left     = '0;
        num_right    = '0;
    endtask

    // leading part of a number: blanks, one sign, or the first digit
    task automatic number_start(input logic [7:0] c, inout logic [15:0] mag,
                                input logic [3:0] body_state);
        if (is_blank(c)) begin
            // stay and skip
        end else if (c == CH_PLUS) begin
            parse_state = body_state;
        end else if (c == CH_MINUS) begin
            sign_neg    = 1'b1;
            parse_state = body_state;
        end else if (is_decimal(c)) begin
            mag         = append_digit(mag, c);
            saw_digit   = 1'b1;
            parse_state = body_state;
        end else begin
            parse_state = PH_FAIL;
        end
    endtask

    task automatic step_parser(input logic [7:0] c);
        case (parse_state)
            PH_DOLLAR: parse_state = (c == CH_DOLLAR) ? PH_LETTER : PH_FAIL;
            PH_LETTER: begin
                if (c == CH_S) begin
                    frame_kind  = CMD_STOP;
                    parse_state = PH_STOP;
                end else if (c == CH_A) begin
                    frame_kind  = CMD_MODE;
                    parse_state = PH_COMMA;
                end else if (c == CH_M) begin
                    frame_kind  = CMD_MOVE;
                    parse_state = PH_COMMA;
                end else begin
                    parse_state = PH_FAIL;
                end
            end
            PH_COMMA: parse_state = (c == CH_COMMA) ? PH_N1_LEAD : PH_FAIL;
            PH_N1_LEAD: number_start(c, num_left, PH_N1_BODY);
            PH_N1_BODY: begin
                if (is_decimal(c)) begin
                    num_left  = append_digit(num_left, c);
                    saw_digit = 1'b1;
                end else if (!saw_digit) begin
                    parse_state = PH_FAIL;
                end else begin
                    num_left = signed_mag(num_left, sign_neg);
                    if (frame_kind == CMD_MODE) begin
                        parse_state = PH_DONE;
                    end else if (c == CH_COMMA) begin
                        sign_neg    = 1'b0;
                        saw_digit   = 1'b0;
                        parse_state = PH_N2_LEAD;
                    end else begin
                        parse_state = PH_FAIL;
                    end
                end
            end
            PH_N2_LEAD: number_start(c, num_right, PH_N2_BODY);
            PH_N2_BODY: begin
                if (is_decimal(c)) begin
                    num_right = append_digit(num_right, c);
                    saw_digit = 1'b1;
                end else if (!saw_digit) begin
                    parse_state = PH_FAIL;
                end else begin
                    num_right   = signed_mag(num_right, sign_neg);
                    parse_state = PH_DONE;
                end
            end
            default: ;
        endcase
    endtask

    // one accepted input transfer; a frame end queues exactly one reply
    task automatic take_event(input logic req, input logic [7:0] c, input logic obs);
        t_result     r;
        logic [15:0] v;
        if (req == REQ_BYTE) begin
            // bytes past a NUL or past the buffer are dropped
            if (!text_stopped && byte_count < FRAME_LIMIT) begin
                byte_count = byte_count + 7'd1;
                if (c == CH_NUL)
                    text_stopped = 1'b1;
                else
                    step_parser(c);
            end
        end else begin
            r = '0;
            if (parse_state == PH_STOP) begin
                r.command = CMD_STOP;
            end else if (frame_kind == CMD_MODE &&
                         ((parse_state == PH_N1_BODY && saw_digit) || parse_state == PH_DONE)) begin
                // a number still open at frame end gets its sign here
                v = (parse_state == PH_N1_BODY) ? signed_mag(num_left, sign_neg) : num_left;
                stored_mode = v[7:0];
                r.command   = CMD_MODE;
            end else if (frame_kind == CMD_MOVE &&
                         ((parse_state == PH_N2_BODY && saw_digit) || parse_state == PH_DONE)) begin
                v = (parse_state == PH_N2_BODY) ? signed_mag(num_right, sign_neg) : num_right;
                r.command     = CMD_MOVE;
                r.left_speed  = forward_clamp(num_left, obs);
                r.right_speed = forward_clamp(v, obs);
            end
            r.mode_now = stored_mode;
            expected_replies.push_back(r);
            clear_frame_state();
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus queue and frame builders
    // ------------------------------------------------------------------
    t_link_event link_events[$];
    int          events_queued   = 0;
    int          events_accepted = 0;
    int          replies_seen    = 0;
    int          error_count     = 0;

    task automatic push_byte(input logic [7:0] c);
        link_events.push_back('{REQ_BYTE, c, 1'($urandom_range(0, 1))});
        events_queued++;
    endtask

    task automatic push_end(input logic obs, input logic [7:0] junk);
        link_events.push_back('{REQ_IDLE, junk, obs});
        events_queued++;
    endtask

    task automatic push_text(input string s);
        for (int k = 0; k < s.len(); k++)
            push_byte(s[k]);
    endtask

    // blanks, optional sign, digits; sometimes no digits, sometimes enough to wrap
    task automatic push_number();
        int sel;
        int n_digits;
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                sel = $urandom_range(0, 5);
                push_byte(sel == 5 ? CH_SPACE : CH_TAB + 8'(sel));
            end
        end
        sel = $urandom_range(0, 3);
        if (sel == 0)
            push_byte(CH_PLUS);
        else if (sel == 1)
            push_byte(CH_MINUS);
        sel = $urandom_range(0, 19);
        if (sel == 0)
            n_digits = 0;
        else if (sel < 3)
            n_digits = $urandom_range(6, 9);
        else
            n_digits = $urandom_range(1, 4);
        repeat (n_digits) push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic push_tail();
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
    endtask

    // mostly well-formed commands with random numbers, the rest broken or noise
    task automatic push_frame();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 18) begin
            push_byte(CH_DOLLAR);
            push_byte(CH_S);
            push_tail();
        end else if (sel < 42) begin
            push_text("$A,");
            push_number();
            push_tail();
        end else if (sel < 72) begin
            push_text("$M,");
            push_number();
            push_byte(CH_COMMA);
            push_number();
            push_tail();
        end else if (sel < 78) begin
            // good start, random command letter
            push_byte(CH_DOLLAR);
            repeat ($urandom_range(1, 5)) push_byte(8'($urandom_range(0, 255)));
        end else if (sel < 84) begin
            // text cut short by a NUL, digits after it must not count
            push_text("$M,");
            push_number();
            push_byte(CH_NUL);
            repeat ($urandom_range(0, 4)) push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
        end else if (sel < 87) begin
            // longer than the buffer: the number is cut at the buffer end
            if (sel[0])
                push_text("$A,");
            else
                push_text("$M,1,");
            repeat ($urandom_range(60, 70)) push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
        end else begin
            repeat ($urandom_range(0, 10)) push_byte(8'($urandom_range(0, 255)));
        end
        push_end(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    endtask

    // sender stays quiet until everything offered is taken and answered
    task automatic drain();
        while (events_accepted != events_queued || expected_replies.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // driver: bursts of transfers with random gaps, changes at the falling edge
    // ------------------------------------------------------------------
    t_link_event next_event;
    logic        offer_taken = 1'b0;
    int          burst_left  = 16;
    int          gap_left    = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || offer_taken) begin
            // a held offer stays put until the monitor sees it taken
            offer_taken = 1'b0;
            if (gap_left != 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (link_events.size() == 0) begin
                i_valid <= 1'b0;
            end else begin
                next_event = link_events.pop_front();
                i_req_type  <= next_event.req;
                i_data_byte <= next_event.ch;
                i_obstacle  <= next_event.obs;
                i_valid     <= 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: a randomly chosen stall style, plus two long hold-offs
    // that fill the result skid and push back on the input side
    // ------------------------------------------------------------------
    int rx_tick    = 0;
    int rx_style   = 0;
    int hold_left  = 0;
    int holds_done = 0;

    always @(negedge i_clk) begin
        rx_tick++;
        if (rx_tick % 100 == 0)
            rx_style = $urandom_range(0, 3);
        if (hold_left != 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (holds_done < 2 && replies_seen >= (holds_done == 0 ? 15 : 50)) begin
            holds_done++;
            hold_left = LONG_HOLD - 1;
            i_stall <= 1'b1;
        end else begin
            case (rx_style)
                0:       i_stall <= 1'b0;
                1:       i_stall <= ($urandom_range(0, 3) == 0);
                2:       i_stall <= ($urandom_range(0, 3) != 0);
                default: i_stall <= (rx_tick % 5 < 2);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks result transfers, feeds input transfers to the model
    // ------------------------------------------------------------------
    t_result want_reply;

    task automatic report_mismatch(input string msg);
        $display("error at result %0d: %s", replies_seen, msg);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                replies_seen++;
                if (expected_replies.size() == 0) begin
                    report_mismatch($sformatf("result with no frame end pending, command %0d",
                                              o_command));
                end else begin
                    want_reply = expected_replies.pop_front();
                    if (o_command !== want_reply.command)
                        report_mismatch($sformatf("command expected %0d got %0d",
                                                  want_reply.command, o_command));
                    if (o_left_speed !== want_reply.left_speed)
                        report_mismatch($sformatf("left speed expected %0d got %0d",
                                                  want_reply.left_speed, o_left_speed));
                    if (o_right_speed !== want_reply.right_speed)
                        report_mismatch($sformatf("right speed expected %0d got %0d",
                                                  want_reply.right_speed, o_right_speed));
                    if (o_mode_now !== want_reply.mode_now)
                        report_mismatch($sformatf("mode expected %0d got %0d",
                                                  want_reply.mode_now, o_mode_now));
                end
            end
            if (i_valid && !o_stall) begin
                take_event(i_req_type, i_data_byte, i_obstacle);
                events_accepted++;
                offer_taken = 1'b1;
            end
        end
    end

    // watchdog: too long with no transfer on either side ends the run
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (o_valid && !i_stall) || (i_valid && !o_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("no transfer for %0d cycles", QUIET_LIMIT);
            $display("serial_command_frame_parser: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence: directed frames, then two random phases with a full drain
    // ------------------------------------------------------------------
    initial begin
        clear_frame_state();
        stored_mode = '0;

        // empty frame, junk on the data lines of the frame end
        push_end(1'b1, 8'hFF);
        // stop
        push_text("$S");
        push_end(1'b0, 8'h00);
        // mode from a negative number keeps its low byte
        push_text("$A,-1");
        push_end(1'b0, 8'h5A);
        // move with a blank before the first number, forward speed blocked
        push_text("$M, 7,-2");
        push_end(1'b1, 8'hA5);
        // NUL ends the text, the byte after it is ignored
        push_byte(CH_DOLLAR);
        push_byte(CH_NUL);
        push_byte(8'hFF);
        push_end(1'b0, 8'h00);

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        drain();
        while (events_queued < RANDOM_EVENTS / 2)
            push_frame();
        drain();
        while (events_queued < RANDOM_EVENTS)
            push_frame();
        drain();
        repeat (20) @(posedge i_clk);

        if (error_count == 0)
            $display("serial_command_frame_parser: match");
        else
            $display("serial_command_frame_parser: mismatch");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/scfp_pkg.sv
rtl/scfp_parse.sv
rtl/scfp_decode.sv
rtl/scfp_out.sv
rtl/serial_command_frame_parser.sv
rtl/scfp_checker.sv
dv/testbench.sv
